### design/rrs_pkg.sv
// Shared types and codes for the round-robin sleep scheduler.
`timescale 1ns / 1ps

package rrs_pkg;

   // Request action codes
   typedef enum logic [2:0] {
      ACT_TICK   = 3'd0,
      ACT_CREATE = 3'd1,
      ACT_START  = 3'd2,
      ACT_YIELD  = 3'd3,
      ACT_SLEEP  = 3'd4,
      ACT_FINISH = 3'd5
   } action_type;

   // Response status codes
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FULL    = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   // Per-slot task state
   typedef enum logic [1:0] {
      SLOT_READY    = 2'd0,
      SLOT_RUNNING  = 2'd1,
      SLOT_SLEEPING = 2'd2,
      SLOT_DEAD     = 2'd3
   } slot_state_type;

   // Sequencer states
   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_WAKE,
      FSM_SEARCH,
      FSM_RUNS_RD,
      FSM_RUNS_WR
   } fsm_type;

   // Shared adder operations
   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      alu_op_type  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_req_type;

   // One response transaction
   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic        chose_idle;
      logic [31:0] run_total;
      logic [31:0] tick_now;
   } rsp_type;

endpackage

### design/rrs_chan_if.sv
// Valid/ready channel interfaces for scheduler requests and responses.
`timescale 1ns / 1ps

interface rrs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [30:0] sleep_ticks;

   modport source (output valid, output action, output sleep_ticks, input ready);
   modport sink   (input valid, input action, input sleep_ticks, output ready);
endinterface

interface rrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  slot;
   logic        chose_idle;
   logic [31:0] run_total;
   logic [31:0] tick_now;

   modport source (output valid, output status, output slot, output chose_idle,
                   output run_total, output tick_now, input ready);
   modport sink   (input valid, input status, input slot, input chose_idle,
                   input run_total, input tick_now, output ready);
endinterface

### design/round_robin_sleep_scheduler_unit.sv
// Top level of the round-robin task-slot scheduler with sleep timers.
`timescale 1ns / 1ps

// Round-robin task-slot scheduler. Slot 0 is the idle task. Each request
// transaction (tick, create, start, yield, sleep, finish) gives exactly one
// response transaction. The block takes one request at a time: tick, create
// and ignored requests are answered from the execute step; a request that
// picks the next slot first sweeps the wake-tick memory (one entry a cycle
// through the shared subtractor), then searches the slot table downward,
// one slot a cycle, and then does a read-modify-write of the run-count
// memory. A response that is not taken holds the block in its final step.
// No clearing pass after reset: run counts carry one valid flop per slot.
module round_robin_sleep_scheduler_unit #(
   parameter int MAX_SLOTS = 16
) (
   input  logic      clock,
   input  logic      reset,
   rrs_req_if.sink   req_ch,
   rrs_rsp_if.source rsp_ch
);

   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int UW = $clog2(MAX_SLOTS + 1);

   // Control registers
   rrs_pkg::fsm_type state_ff, state_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [SW-1:0]    cur_ff, cur_in;
   logic             has_cur_ff, has_cur_in;
   logic             running_ff, running_in;
   logic [31:0]      tick_ff, tick_in;
   logic [UW-1:0]    wk_cnt_ff, wk_cnt_in;
   logic             wk_pend_ff, wk_pend_in;
   logic [UW-1:0]    sr_left_ff, sr_left_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Payload registers
   logic [2:0]       act_ff, act_in;
   logic [30:0]      ticks_ff, ticks_in;
   logic [SW-1:0]    wk_prev_ff, wk_prev_in;
   logic [SW-1:0]    sr_idx_ff, sr_idx_in;
   logic [SW-1:0]    found_ff, found_in;
   logic             got_ff, got_in;
   rrs_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Slot table, wake-tick and run-count stores
   rrs_pkg::slot_state_type slot_state_ff [MAX_SLOTS];
   logic [MAX_SLOTS-1:0]    runs_vld_ff;
   logic [31:0]             wake_mem [MAX_SLOTS];
   logic [31:0]             runs_mem [MAX_SLOTS];
   logic [31:0]             wake_rd_ff;
   logic [31:0]             runs_rd_ff;
   logic                    vld_rd_ff;

   // Store access controls
   logic [SW-1:0]           st_raddr;
   rrs_pkg::slot_state_type st_rd;
   logic                    st_we;
   logic [SW-1:0]           st_waddr;
   rrs_pkg::slot_state_type st_wdata;
   logic                    wk_we, wk_re;
   logic [SW-1:0]           wk_raddr;
   logic                    runs_we, runs_re;
   logic                    vld_clr, vld_set;
   logic                    can_load;
   logic [SW-1:0]           last_idx;
   logic [UW-1:0]           used_m1;
   logic [31:0]             runs_base;

   rrs_pkg::alu_req_type alu_req;
   logic [31:0]          alu_y;

   rrs_alu u_alu (
      .req (alu_req),
      .y   (alu_y)
   );

   // Low four bits of a slot index for the response
   function automatic logic [3:0] slot4(input logic [SW-1:0] idx);
      logic [7:0] w;
      w = 8'(idx);
      return w[3:0];
   endfunction

   assign can_load  = !rsp_valid_ff || rsp_ch.ready;
   assign used_m1   = used_ff - UW'(1);
   assign last_idx  = used_m1[SW-1:0];
   assign runs_base = vld_rd_ff ? runs_rd_ff : 32'd0;

   // Slot table read port, address chosen by the step
   always_comb begin
      case (state_ff)
         rrs_pkg::FSM_WAKE:   st_raddr = wk_prev_ff;
         rrs_pkg::FSM_SEARCH: st_raddr = sr_idx_ff;
         default:             st_raddr = cur_ff;
      endcase
   end

   assign st_rd = slot_state_ff[st_raddr];

   // Sequencer: next state and store controls
   always_comb begin
      state_in    = state_ff;
      used_in     = used_ff;
      cur_in      = cur_ff;
      has_cur_in  = has_cur_ff;
      running_in  = running_ff;
      tick_in     = tick_ff;
      wk_cnt_in   = wk_cnt_ff;
      wk_pend_in  = wk_pend_ff;
      sr_left_in  = sr_left_ff;
      act_in      = act_ff;
      ticks_in    = ticks_ff;
      wk_prev_in  = wk_prev_ff;
      sr_idx_in   = sr_idx_ff;
      found_in    = found_ff;
      got_in      = got_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      alu_req     = '{op: rrs_pkg::ALU_ADD, a: tick_ff, b: 32'd1};
      st_we       = 1'b0;
      st_waddr    = cur_ff;
      st_wdata    = rrs_pkg::SLOT_READY;
      wk_we       = 1'b0;
      wk_re       = 1'b0;
      wk_raddr    = wk_cnt_ff[SW-1:0];
      runs_we     = 1'b0;
      runs_re     = 1'b0;
      vld_clr     = 1'b0;
      vld_set     = 1'b0;
      req_ch.ready = (state_ff == rrs_pkg::FSM_IDLE);

      case (state_ff)
         rrs_pkg::FSM_IDLE: begin
            if (req_ch.valid) begin
               act_in   = req_ch.action;
               ticks_in = req_ch.sleep_ticks;
               state_in = rrs_pkg::FSM_EXEC;
            end
         end

         rrs_pkg::FSM_EXEC: begin
            if (can_load) begin
               // default: ignored transaction, answered at once
               rsp_data_in = '{status: rrs_pkg::STATUS_IGNORED, slot: slot4(cur_ff),
                               chose_idle: 1'b0, run_total: 32'd0, tick_now: tick_ff};
               rsp_valid_in = 1'b1;
               state_in     = rrs_pkg::FSM_IDLE;
               case (act_ff)
                  rrs_pkg::ACT_TICK: begin
                     tick_in = alu_y;
                     rsp_data_in.status   = rrs_pkg::STATUS_OK;
                     rsp_data_in.tick_now = alu_y;
                  end
                  rrs_pkg::ACT_CREATE: begin
                     if (used_ff >= UW'(MAX_SLOTS)) begin
                        rsp_data_in.status = rrs_pkg::STATUS_FULL;
                        rsp_data_in.slot   = 4'd0;
                     end else begin
                        st_we    = 1'b1;
                        st_waddr = used_ff[SW-1:0];
                        st_wdata = rrs_pkg::SLOT_READY;
                        vld_clr  = 1'b1;
                        used_in  = used_ff + UW'(1);
                        rsp_data_in.status = rrs_pkg::STATUS_OK;
                        rsp_data_in.slot   = slot4(used_ff[SW-1:0]);
                     end
                  end
                  rrs_pkg::ACT_START: begin
                     if (!running_ff) begin
                        running_in   = 1'b1;
                        rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
                        rsp_data_in  = rsp_data_ff;
                        wk_cnt_in    = '0;
                        wk_pend_in   = 1'b0;
                        state_in     = rrs_pkg::FSM_WAKE;
                     end
                  end
                  rrs_pkg::ACT_YIELD, rrs_pkg::ACT_SLEEP, rrs_pkg::ACT_FINISH: begin
                     if (running_ff && has_cur_ff) begin
                        rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
                        rsp_data_in  = rsp_data_ff;
                        wk_cnt_in    = '0;
                        wk_pend_in   = 1'b0;
                        state_in     = rrs_pkg::FSM_WAKE;
                        if (act_ff == rrs_pkg::ACT_SLEEP && ticks_ff != 31'd0) begin
                           // wake tick = now + length
                           alu_req  = '{op: rrs_pkg::ALU_ADD, a: tick_ff,
                                        b: {1'b0, ticks_ff}};
                           wk_we    = 1'b1;
                           st_we    = 1'b1;
                           st_wdata = rrs_pkg::SLOT_SLEEPING;
                        end else if (act_ff == rrs_pkg::ACT_FINISH && cur_ff != '0) begin
                           st_we    = 1'b1;
                           st_wdata = rrs_pkg::SLOT_DEAD;
                        end else if (st_rd == rrs_pkg::SLOT_RUNNING) begin
                           // yield, zero-length sleep, or finish of idle
                           st_we    = 1'b1;
                           st_wdata = rrs_pkg::SLOT_READY;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         rrs_pkg::FSM_WAKE: begin
            // check the entry read last cycle: due when wake - now <= 0
            alu_req = '{op: rrs_pkg::ALU_SUB, a: wake_rd_ff, b: tick_ff};
            if (wk_pend_ff && st_rd == rrs_pkg::SLOT_SLEEPING &&
                (alu_y == 32'd0 || alu_y[31])) begin
               st_we    = 1'b1;
               st_waddr = wk_prev_ff;
               st_wdata = rrs_pkg::SLOT_READY;
            end
            // issue the next read
            if (wk_cnt_ff < used_ff) begin
               wk_re      = 1'b1;
               wk_prev_in = wk_cnt_ff[SW-1:0];
               wk_cnt_in  = wk_cnt_ff + UW'(1);
               wk_pend_in = 1'b1;
            end else begin
               wk_pend_in = 1'b0;
               if (!wk_pend_ff) begin
                  // search starts just below the current slot, else at the last used slot
                  if (has_cur_ff && UW'(cur_ff) < used_ff) begin
                     sr_idx_in = (cur_ff == '0) ? last_idx : cur_ff - SW'(1);
                  end else begin
                     sr_idx_in = last_idx;
                  end
                  sr_left_in = used_ff;
                  state_in   = rrs_pkg::FSM_SEARCH;
               end
            end
         end

         rrs_pkg::FSM_SEARCH: begin
            if (sr_idx_ff != '0 && st_rd == rrs_pkg::SLOT_READY) begin
               found_in = sr_idx_ff;
               got_in   = 1'b1;
               state_in = rrs_pkg::FSM_RUNS_RD;
            end else if (sr_left_ff == UW'(1)) begin
               found_in = '0;
               got_in   = 1'b0;
               state_in = rrs_pkg::FSM_RUNS_RD;
            end else begin
               sr_idx_in  = (sr_idx_ff == '0) ? last_idx : sr_idx_ff - SW'(1);
               sr_left_in = sr_left_ff - UW'(1);
            end
         end

         rrs_pkg::FSM_RUNS_RD: begin
            st_we      = 1'b1;
            st_waddr   = found_ff;
            st_wdata   = rrs_pkg::SLOT_RUNNING;
            runs_re    = 1'b1;
            cur_in     = found_ff;
            has_cur_in = 1'b1;
            state_in   = rrs_pkg::FSM_RUNS_WR;
         end

         rrs_pkg::FSM_RUNS_WR: begin
            alu_req = '{op: rrs_pkg::ALU_ADD, a: runs_base, b: 32'd1};
            if (can_load) begin
               runs_we      = 1'b1;
               vld_set      = 1'b1;
               rsp_data_in  = '{status: rrs_pkg::STATUS_OK, slot: slot4(found_ff),
                                chose_idle: !got_ff, run_total: alu_y, tick_now: tick_ff};
               rsp_valid_in = 1'b1;
               state_in     = rrs_pkg::FSM_IDLE;
            end
         end

         default: begin
            state_in = rrs_pkg::FSM_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrs_pkg::FSM_IDLE;
         used_ff      <= UW'(1);
         cur_ff       <= '0;
         has_cur_ff   <= 1'b0;
         running_ff   <= 1'b0;
         tick_ff      <= 32'd0;
         wk_cnt_ff    <= '0;
         wk_pend_ff   <= 1'b0;
         sr_left_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cur_ff       <= cur_in;
         has_cur_ff   <= has_cur_in;
         running_ff   <= running_in;
         tick_ff      <= tick_in;
         wk_cnt_ff    <= wk_cnt_in;
         wk_pend_ff   <= wk_pend_in;
         sr_left_ff   <= sr_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      ticks_ff    <= ticks_in;
      wk_prev_ff  <= wk_prev_in;
      sr_idx_ff   <= sr_idx_in;
      found_ff    <= found_in;
      got_ff      <= got_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Slot table: one write port, idle slot ready after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SLOTS; i++) begin
            slot_state_ff[i] <= (i == 0) ? rrs_pkg::SLOT_READY : rrs_pkg::SLOT_DEAD;
         end
      end else if (st_we) begin
         slot_state_ff[st_waddr] <= st_wdata;
      end
   end

   // Run-count valid bits: an invalid entry reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         runs_vld_ff <= '0;
      end else if (vld_clr) begin
         runs_vld_ff[used_ff[SW-1:0]] <= 1'b0;
      end else if (vld_set) begin
         runs_vld_ff[found_ff] <= 1'b1;
      end
   end

   // Wake-tick memory, registered read
   always_ff @(posedge clock) begin
      if (wk_we) begin
         wake_mem[cur_ff] <= alu_y;
      end
      if (wk_re) begin
         wake_rd_ff <= wake_mem[wk_raddr];
      end
   end

   // Run-count memory, registered read
   always_ff @(posedge clock) begin
      if (runs_we) begin
         runs_mem[found_ff] <= alu_y;
      end
      if (runs_re) begin
         runs_rd_ff <= runs_mem[found_ff];
         vld_rd_ff  <= runs_vld_ff[found_ff];
      end
   end

   // Response channel
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_data_ff.status;
   assign rsp_ch.slot       = rsp_data_ff.slot;
   assign rsp_ch.chose_idle = rsp_data_ff.chose_idle;
   assign rsp_ch.run_total  = rsp_data_ff.run_total;
   assign rsp_ch.tick_now   = rsp_data_ff.tick_now;

   // Slot count stays within the table
   a_used_range: assert property (@(posedge clock) disable iff (reset)
      used_ff != '0 && used_ff <= UW'(MAX_SLOTS))
      else $error("slot count out of range");

   // The idle slot is never killed
   a_idle_alive: assert property (@(posedge clock) disable iff (reset)
      slot_state_ff[0] != rrs_pkg::SLOT_DEAD)
      else $error("idle slot dead");

   // Between transactions the current slot is the running one
   a_cur_running: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrs_pkg::FSM_IDLE && has_cur_ff |->
      slot_state_ff[cur_ff] == rrs_pkg::SLOT_RUNNING)
      else $error("current slot not running");

   // A pick that fell back to idle reports slot zero
   a_idle_pick: assert property (@(posedge clock) disable iff (reset)
      state_ff == rrs_pkg::FSM_RUNS_WR && can_load && !got_ff |=>
      rsp_ch.valid && rsp_ch.chose_idle && rsp_ch.slot == 4'd0)
      else $error("idle pick reported wrong slot");

endmodule

### design/rrs_alu.sv
// Shared 32-bit add/subtract unit for the tick, wake-tick and run-count arithmetic.
`timescale 1ns / 1ps

module rrs_alu (
   input  rrs_pkg::alu_req_type req,
   output logic [31:0]          y
);

   // One wrapping adder, subtract for the wake-time difference
   always_comb begin
      case (req.op)
         rrs_pkg::ALU_ADD: y = req.a + req.b;
         rrs_pkg::ALU_SUB: y = req.a - req.b;
         default:          y = req.a + req.b;
      endcase
   end

endmodule

### verif/round_robin_sleep_scheduler_unit_test.sv
// Self-checking testbench for the round-robin sleep scheduler: directed and random transactions.
`timescale 1ns / 1ps

module round_robin_sleep_scheduler_unit_test;

   localparam int SLOTS       = 16;
   localparam int RANDOM_REQS = 650;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 2 * SLOTS + 10;

   // One request transaction as offered to the block
   typedef struct {
      logic [2:0]  action;
      logic [30:0] ticks;
   } sched_req_type;

   logic clock;
   logic reset;

   rrs_req_if req_if ();
   rrs_rsp_if rsp_if ();

   round_robin_sleep_scheduler_unit #(
      .MAX_SLOTS (SLOTS)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Stimulus, expected responses and bookkeeping
   sched_req_type    request_q[$];
   rrs_pkg::rsp_type outcome_q[$];
   int               mismatches;
   int               rsp_seen;
   int               cycle_count;
   int               hold_left;
   logic             hold_done;
   int               send_gap, send_calm;
   int               recv_gap, recv_calm;

   // Shadow copy of the scheduler state
   rrs_pkg::slot_state_type sch_state [SLOTS];
   logic [31:0]             sch_wake  [SLOTS];
   logic [31:0]             sch_runs  [SLOTS];
   logic [31:0]             sch_last  [SLOTS];
   logic [4:0]              sch_used;
   logic [3:0]              sch_cur;
   logic                    sch_has_cur;
   logic                    sch_running;
   logic [31:0]             sch_tick;

   always #10 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic int next_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [30:0] rand_ticks();
      logic [31:0] w;
      w = $urandom();
      return w[30:0];
   endfunction

   task automatic queue_req(input logic [2:0] act, input logic [30:0] dur);
      sched_req_type item;
      item.action = act;
      item.ticks  = dur;
      request_q.push_back(item);
   endtask

   // Wake due sleepers, search downward from below the current slot, run the winner
   task automatic pick_next_slot(inout rrs_pkg::rsp_type r);
      int          n, idx, found;
      logic        got;
      logic [31:0] diff;
      n = sch_used;
      for (int i = 0; i < n; i++) begin
         if (sch_state[i] == rrs_pkg::SLOT_SLEEPING) begin
            diff = sch_wake[i] - sch_tick;
            if (diff == 0 || diff[31]) sch_state[i] = rrs_pkg::SLOT_READY;
         end
      end
      if (sch_has_cur && sch_cur < n) idx = (sch_cur == 0) ? n - 1 : sch_cur - 1;
      else idx = n - 1;
      found = 0;
      got   = 1'b0;
      for (int i = 0; i < n && !got; i++) begin
         if (idx != 0 && sch_state[idx] == rrs_pkg::SLOT_READY) begin
            found = idx;
            got   = 1'b1;
         end else begin
            idx = (idx == 0) ? n - 1 : idx - 1;
         end
      end
      sch_state[found] = rrs_pkg::SLOT_RUNNING;
      sch_runs[found]  = sch_runs[found] + 1;
      sch_last[found]  = sch_tick;
      sch_cur          = found[3:0];
      sch_has_cur      = 1'b1;
      r.slot           = found[3:0];
      r.chose_idle     = !got;
      r.run_total      = sch_runs[found];
   endtask

   // Apply one accepted transaction to the shadow state and form its response
   task automatic sched_apply(input logic [2:0] act, input logic [30:0] dur,
                              output rrs_pkg::rsp_type r);
      logic [3:0] s;
      logic       active;
      active       = sch_running && sch_has_cur;
      r.status     = rrs_pkg::STATUS_OK;
      r.slot       = sch_cur;
      r.chose_idle = 1'b0;
      r.run_total  = '0;
      case (act)
         rrs_pkg::ACT_TICK: begin
            sch_tick = sch_tick + 1;
         end
         rrs_pkg::ACT_CREATE: begin
            if (sch_used >= SLOTS) begin
               r.status = rrs_pkg::STATUS_FULL;
               r.slot   = '0;
            end else begin
               s            = sch_used[3:0];
               sch_state[s] = rrs_pkg::SLOT_READY;
               sch_wake[s]  = '0;
               sch_runs[s]  = '0;
               sch_last[s]  = '0;
               sch_used     = sch_used + 1;
               r.slot       = s;
            end
         end
         rrs_pkg::ACT_START: begin
            if (sch_running) begin
               r.status = rrs_pkg::STATUS_IGNORED;
            end else begin
               sch_running = 1'b1;
               pick_next_slot(r);
            end
         end
         rrs_pkg::ACT_YIELD, rrs_pkg::ACT_SLEEP, rrs_pkg::ACT_FINISH: begin
            if (!active) begin
               r.status = rrs_pkg::STATUS_IGNORED;
            end else begin
               if (act == rrs_pkg::ACT_SLEEP && dur != 0) begin
                  sch_state[sch_cur] = rrs_pkg::SLOT_SLEEPING;
                  sch_wake[sch_cur]  = sch_tick + {1'b0, dur};
               end else if (act == rrs_pkg::ACT_FINISH && sch_cur != 0) begin
                  // idle can never be killed; finish of idle acts as a yield
                  sch_state[sch_cur] = rrs_pkg::SLOT_DEAD;
               end else if (sch_state[sch_cur] == rrs_pkg::SLOT_RUNNING) begin
                  sch_state[sch_cur] = rrs_pkg::SLOT_READY;
               end
               pick_next_slot(r);
            end
         end
         default: begin
            r.status = rrs_pkg::STATUS_IGNORED;
         end
      endcase
      r.tick_now = sch_tick;
   endtask

   // Request driver: offers queued transactions with random gaps
   always @(posedge clock) begin : drive_req
      sched_req_type    item;
      rrs_pkg::rsp_type want;
      logic             offer;
      if (reset) begin
         req_if.valid <= 1'b0;
         send_gap = 0;
         send_calm = 0;
      end else begin
         offer = req_if.valid;
         if (req_if.valid && req_if.ready) begin
            sched_apply(req_if.action, req_if.sleep_ticks, want);
            outcome_q.push_back(want);
            offer = 1'b0;
            if (send_calm != 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = next_gap();
               if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(20, 60);
            end
         end
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (request_q.size() != 0) begin
               item = request_q.pop_front();
               req_if.action      <= item.action;
               req_if.sleep_ticks <= item.ticks;
               offer = 1'b1;
            end
         end
         req_if.valid <= offer;
      end
   end

   // Response monitor: checks each accepted transaction against the oldest expectation
   always @(posedge clock) begin : watch_rsp
      rrs_pkg::rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_seen     <= 0;
         recv_gap = 0;
         recv_calm = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_seen <= rsp_seen + 1;
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("unexpected response slot=%0d status=%0d",
                                         rsp_if.slot, rsp_if.status));
            end else begin
               want = outcome_q.pop_front();
               if (rsp_if.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_if.status, want.status));
               if (rsp_if.slot !== want.slot)
                  report_mismatch($sformatf("slot got %0d want %0d",
                                            rsp_if.slot, want.slot));
               if (rsp_if.chose_idle !== want.chose_idle)
                  report_mismatch($sformatf("chose_idle got %0b want %0b",
                                            rsp_if.chose_idle, want.chose_idle));
               if (rsp_if.run_total !== want.run_total)
                  report_mismatch($sformatf("run_total got %0d want %0d",
                                            rsp_if.run_total, want.run_total));
               if (rsp_if.tick_now !== want.tick_now)
                  report_mismatch($sformatf("tick_now got %0d want %0d",
                                            rsp_if.tick_now, want.tick_now));
            end
            if (recv_calm != 0) begin
               recv_calm--;
            end else begin
               recv_gap = next_gap();
               if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(20, 60);
            end
         end else if (recv_gap == 0 && recv_calm == 0 && $urandom_range(0, 15) == 0) begin
            recv_gap = $urandom_range(1, 4);
         end
         // back-pressure: long hold, then per-transaction gaps
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Long receiver hold so the block backs up while requests keep coming
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_seen >= 120) begin
         hold_left <= 500;
         hold_done <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      int          r;
      logic [2:0]  act;
      logic [30:0] dur;
      clock              = 1'b0;
      reset              = 1'b1;
      cycle_count        = 0;
      mismatches         = 0;
      req_if.valid       = 1'b0;
      req_if.action      = rrs_pkg::ACT_TICK;
      req_if.sleep_ticks = '0;
      rsp_if.ready       = 1'b0;

      // shadow state after reset
      for (int i = 0; i < SLOTS; i++) begin
         sch_state[i] = rrs_pkg::SLOT_DEAD;
         sch_wake[i]  = '0;
         sch_runs[i]  = '0;
         sch_last[i]  = '0;
      end
      sch_state[0] = rrs_pkg::SLOT_READY;
      sch_used     = 5'd1;
      sch_cur      = '0;
      sch_has_cur  = 1'b0;
      sch_running  = 1'b0;
      sch_tick     = '0;

      // directed: ignored actions before start, idle handling, basic rotation
      queue_req(rrs_pkg::ACT_YIELD, '0);
      queue_req(rrs_pkg::ACT_SLEEP, 31'd5);
      queue_req(rrs_pkg::ACT_FINISH, '0);
      queue_req(3'd6, 31'h2AAA_AAAA);
      queue_req(3'd7, 31'h5555_5555);
      queue_req(rrs_pkg::ACT_TICK, '0);
      queue_req(rrs_pkg::ACT_START, '0);         // nothing else ready: idle chosen
      queue_req(rrs_pkg::ACT_START, '0);         // already running
      queue_req(rrs_pkg::ACT_FINISH, '0);        // finish of idle
      queue_req(rrs_pkg::ACT_SLEEP, '0);         // zero-length sleep
      queue_req(rrs_pkg::ACT_SLEEP, 31'd3);      // idle sleeps but is still taken
      queue_req(rrs_pkg::ACT_CREATE, '0);
      queue_req(rrs_pkg::ACT_CREATE, '0);
      queue_req(rrs_pkg::ACT_YIELD, '0);
      queue_req(rrs_pkg::ACT_YIELD, '0);
      queue_req(rrs_pkg::ACT_SLEEP, 31'd2);
      queue_req(rrs_pkg::ACT_TICK, '0);
      queue_req(rrs_pkg::ACT_TICK, '0);
      queue_req(rrs_pkg::ACT_YIELD, '0);         // sleeper woken by the pick
      queue_req(rrs_pkg::ACT_FINISH, '0);
      queue_req(rrs_pkg::ACT_SLEEP, 31'h7FFF_FFFF);
      queue_req(rrs_pkg::ACT_TICK, 31'h7FFF_FFFF);
      queue_req(rrs_pkg::ACT_CREATE, '0);
      queue_req(rrs_pkg::ACT_YIELD, '0);

      // random: mostly ticks, yields and short sleeps; rare finishes and long sleeps
      for (int k = 0; k < RANDOM_REQS; k++) begin
         r   = $urandom_range(0, 99);
         dur = rand_ticks();
         if (r < 30) act = rrs_pkg::ACT_TICK;
         else if (r < 38) act = rrs_pkg::ACT_CREATE;
         else if (r < 40) act = rrs_pkg::ACT_START;
         else if (r < 63) act = rrs_pkg::ACT_YIELD;
         else if (r < 95) act = rrs_pkg::ACT_SLEEP;
         else if (r < 97) act = rrs_pkg::ACT_FINISH;
         else act = ($urandom_range(0, 1) != 0) ? 3'd6 : 3'd7;
         if (act == rrs_pkg::ACT_SLEEP) begin
            r = $urandom_range(0, 99);
            if (r < 8) dur = '0;
            else if (r < 98) dur = 31'($urandom_range(1, 12));
         end
         queue_req(act, dur);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, accepted and answered
      @(negedge clock);
      while (request_q.size() != 0 || req_if.valid || outcome_q.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### round_robin_sleep_scheduler_unit.f
design/rrs_pkg.sv
design/rrs_chan_if.sv
design/rrs_alu.sv
design/round_robin_sleep_scheduler_unit.sv
verif/round_robin_sleep_scheduler_unit_test.sv
